>>> rtl/ecal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecal_pkg - shared definitions for the epoch-to-calendar converter
// Command codes, divisor selects, datapath widths and calendar constants used
// by the controller and the datapath.
// ----------------------------------------------------------------------------
package ecal_pkg;

    // field widths
    localparam int EPOCH_W  = 32;
    localparam int ZONE_W   = 17;
    localparam int YEAR_W   = 12;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;

    // local time biased by one day, always positive and below 2^33
    localparam int LOCAL_W = 33;

    // shared constant divider: dividend, reciprocal, quotient, divisor, remainder
    localparam int DIV_SHIFT = 26;
    localparam int DX_W      = 26;
    localparam int DM_W      = 21;
    localparam int PROD_W    = DX_W + DM_W;
    localparam int DQ_W      = 21;
    localparam int DD_W      = 12;
    localparam int DR_W      = 12;
    localparam int QD_W      = DQ_W + DD_W;
    localparam int CHK_W     = DX_W + 1;

    // calendar working widths
    localparam int DAYS_W = 16;
    localparam int SOD_W  = 17;
    localparam int DOE_W  = 18;
    localparam int YOE_W  = 9;
    localparam int DOY_W  = 9;
    localparam int MP_W   = 4;

    localparam logic [ZONE_W-1:0]  ZONE_RESET = 17'd28800;
    localparam logic [LOCAL_W-1:0] DAY_BIAS   = 33'd86400;

    // biased day count at which the era starting 2000-03-01 begins
    localparam logic [DAYS_W-1:0] ERA5_FIRST  = 16'd11018;
    // day of era for the biased day count, era starting 1600-03-01
    localparam logic [DOE_W-1:0]  ERA4_OFFSET = 18'd135079;

    localparam logic [YEAR_W-1:0] ERA4_YEAR = 12'd1600;
    localparam logic [YEAR_W-1:0] ERA5_YEAR = 12'd2000;

    // divisors
    localparam logic [DD_W-1:0] DIV_DAY  = 12'd675;   // 86400 >> 7
    localparam logic [DD_W-1:0] DIV_CYC  = 12'd1460;
    localparam logic [DD_W-1:0] DIV_YEAR = 12'd365;
    localparam logic [DD_W-1:0] DIV_HOUR = 12'd3600;
    localparam logic [DD_W-1:0] DIV_MIN  = 12'd60;

    // reciprocals, floor(2^DIV_SHIFT / d)
    localparam logic [DM_W-1:0] RECIP_DAY  = DM_W'((64'd1 << DIV_SHIFT) / 64'd675);
    localparam logic [DM_W-1:0] RECIP_CYC  = DM_W'((64'd1 << DIV_SHIFT) / 64'd1460);
    localparam logic [DM_W-1:0] RECIP_YEAR = DM_W'((64'd1 << DIV_SHIFT) / 64'd365);
    localparam logic [DM_W-1:0] RECIP_HOUR = DM_W'((64'd1 << DIV_SHIFT) / 64'd3600);
    localparam logic [DM_W-1:0] RECIP_MIN  = DM_W'((64'd1 << DIV_SHIFT) / 64'd60);

    // divisor selects, in order of use
    localparam int DSEL_W = 3;
    localparam logic [DSEL_W-1:0] DV_DAY  = 3'd0;
    localparam logic [DSEL_W-1:0] DV_CYC  = 3'd1;
    localparam logic [DSEL_W-1:0] DV_YEAR = 3'd2;
    localparam logic [DSEL_W-1:0] DV_HOUR = 3'd3;
    localparam logic [DSEL_W-1:0] DV_MIN  = 3'd4;

    // datapath commands
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NONE    = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD    = 4'd1;
    localparam logic [OP_W-1:0] OP_MUL     = 4'd2;
    localparam logic [OP_W-1:0] OP_QD      = 4'd3;
    localparam logic [OP_W-1:0] OP_FIX     = 4'd4;
    localparam logic [OP_W-1:0] OP_DAYS    = 4'd5;
    localparam logic [OP_W-1:0] OP_TSUM    = 4'd6;
    localparam logic [OP_W-1:0] OP_YDAYS   = 4'd7;
    localparam logic [OP_W-1:0] OP_DOY     = 4'd8;
    localparam logic [OP_W-1:0] OP_MONTH   = 4'd9;
    localparam logic [OP_W-1:0] OP_DATE    = 4'd10;
    localparam logic [OP_W-1:0] OP_HOUR    = 4'd11;
    localparam logic [OP_W-1:0] OP_PUBLISH = 4'd12;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [DSEL_W-1:0] dsel;
    } t_cmd;

    function automatic logic [DD_W-1:0] div_value(input logic [DSEL_W-1:0] sel);
        logic [DD_W-1:0] d;
        unique case (sel)
            DV_DAY:  d = DIV_DAY;
            DV_CYC:  d = DIV_CYC;
            DV_YEAR: d = DIV_YEAR;
            DV_HOUR: d = DIV_HOUR;
            DV_MIN:  d = DIV_MIN;
            default: d = DIV_MIN;
        endcase
        return d;
    endfunction

    function automatic logic [DM_W-1:0] div_recip(input logic [DSEL_W-1:0] sel);
        logic [DM_W-1:0] m;
        unique case (sel)
            DV_DAY:  m = RECIP_DAY;
            DV_CYC:  m = RECIP_CYC;
            DV_YEAR: m = RECIP_YEAR;
            DV_HOUR: m = RECIP_HOUR;
            DV_MIN:  m = RECIP_MIN;
            default: m = RECIP_MIN;
        endcase
        return m;
    endfunction

    // first day of each month in a March-based year
    function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
        logic [DOY_W-1:0] s;
        unique case (mp)
            4'd0:    s = 9'd0;
            4'd1:    s = 9'd31;
            4'd2:    s = 9'd61;
            4'd3:    s = 9'd92;
            4'd4:    s = 9'd122;
            4'd5:    s = 9'd153;
            4'd6:    s = 9'd184;
            4'd7:    s = 9'd214;
            4'd8:    s = 9'd245;
            4'd9:    s = 9'd275;
            4'd10:   s = 9'd306;
            4'd11:   s = 9'd337;
            default: s = 9'd0;
        endcase
        return s;
    endfunction

endpackage

>>> rtl/ecal_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecal_dpath - datapath of the epoch-to-calendar converter
// Zone register, a shared reciprocal divider (multiply, back-multiply, fix-up)
// and the calendar steps, each run on a command from the controller.
// ----------------------------------------------------------------------------
module ecal_dpath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ecal_pkg::t_cmd                 i_cmd,
    input  logic [ecal_pkg::EPOCH_W-1:0]   i_epoch_seconds,
    input  logic                           i_cfg_wr_en,
    input  logic [ecal_pkg::ZONE_W-1:0]    i_cfg_wr_data,
    output logic [ecal_pkg::YEAR_W-1:0]    o_year,
    output logic [ecal_pkg::MONTH_W-1:0]   o_month,
    output logic [ecal_pkg::DAY_W-1:0]     o_day,
    output logic [ecal_pkg::HOUR_W-1:0]    o_hour,
    output logic [ecal_pkg::MINUTE_W-1:0]  o_minute,
    output logic [ecal_pkg::SECOND_W-1:0]  o_second
);

    // zone offset register
    logic [ecal_pkg::ZONE_W-1:0] r_zone;

    // divider
    logic [ecal_pkg::DX_W-1:0]   r_dx,   n_dx;
    logic [ecal_pkg::PROD_W-1:0] r_prod, n_prod;
    logic [ecal_pkg::DQ_W-1:0]   r_dq,   n_dq;
    logic [ecal_pkg::DX_W-1:0]   r_dqd,  n_dqd;
    logic [ecal_pkg::DR_W-1:0]   r_dr,   n_dr;

    // calendar working registers
    logic [6:0]                     r_low7,  n_low7;
    logic [ecal_pkg::SOD_W-1:0]     r_sod,   n_sod;
    logic                           r_era5,  n_era5;
    logic [ecal_pkg::DOE_W-1:0]     r_doe,   n_doe;
    logic [ecal_pkg::YOE_W-1:0]     r_yoe,   n_yoe;
    logic [ecal_pkg::DOE_W-1:0]     r_ydays, n_ydays;
    logic [ecal_pkg::DOY_W-1:0]     r_doy,   n_doy;
    logic [ecal_pkg::MP_W-1:0]      r_mp,    n_mp;
    logic [ecal_pkg::DAY_W-1:0]     r_day,   n_day;
    logic [ecal_pkg::MONTH_W-1:0]   r_month, n_month;
    logic [ecal_pkg::YEAR_W-1:0]    r_year,  n_year;
    logic [ecal_pkg::HOUR_W-1:0]    r_hour,  n_hour;

    // result register
    logic [ecal_pkg::YEAR_W-1:0]    r_out_year,   n_out_year;
    logic [ecal_pkg::MONTH_W-1:0]   r_out_month,  n_out_month;
    logic [ecal_pkg::DAY_W-1:0]     r_out_day,    n_out_day;
    logic [ecal_pkg::HOUR_W-1:0]    r_out_hour,   n_out_hour;
    logic [ecal_pkg::MINUTE_W-1:0]  r_out_minute, n_out_minute;
    logic [ecal_pkg::SECOND_W-1:0]  r_out_second, n_out_second;

    logic [ecal_pkg::DD_W-1:0]    w_div_d;
    logic [ecal_pkg::DM_W-1:0]    w_div_m;
    logic [ecal_pkg::LOCAL_W-1:0] w_local;
    logic [ecal_pkg::DQ_W-1:0]    w_q0;
    logic [ecal_pkg::QD_W-1:0]    w_qd_full;
    logic [ecal_pkg::DX_W-1:0]    w_rem;
    logic [ecal_pkg::DAYS_W-1:0]  w_days;
    logic [ecal_pkg::DOE_W-1:0]   w_doe;
    logic [1:0]                   w_c36524;
    logic [ecal_pkg::YOE_W-1:0]   w_yoe;
    logic [1:0]                   w_c100;
    logic [ecal_pkg::MP_W-1:0]    w_mp;
    logic [ecal_pkg::DOY_W-1:0]   w_dstart;
    logic                         w_early;

    assign w_div_d = ecal_pkg::div_value(i_cmd.dsel);
    assign w_div_m = ecal_pkg::div_recip(i_cmd.dsel);

    // local time plus one day, never negative
    assign w_local = ecal_pkg::LOCAL_W'(i_epoch_seconds)
                   + {{(ecal_pkg::LOCAL_W - ecal_pkg::ZONE_W){r_zone[ecal_pkg::ZONE_W-1]}},
                      r_zone}
                   + ecal_pkg::DAY_BIAS;

    // quotient estimate is exact or one short
    assign w_q0      = r_prod[ecal_pkg::PROD_W-1:ecal_pkg::DIV_SHIFT];
    assign w_qd_full = ecal_pkg::QD_W'(w_q0) * ecal_pkg::QD_W'(w_div_d);
    assign w_rem     = r_dx - r_dqd;

    // era split: biased day count straight to day of era
    assign w_days = r_dq[ecal_pkg::DAYS_W-1:0];
    assign w_doe  = (w_days >= ecal_pkg::ERA5_FIRST)
                  ? ecal_pkg::DOE_W'(w_days - ecal_pkg::ERA5_FIRST)
                  : ecal_pkg::DOE_W'(w_days) + ecal_pkg::ERA4_OFFSET;

    // doe/36524 minus the last-day-of-era term; they cancel at the top
    assign w_c36524 = 2'(r_doe >= 18'd36524) + 2'(r_doe >= 18'd73048)
                    + 2'(r_doe >= 18'd109572);

    assign w_yoe  = r_dq[ecal_pkg::YOE_W-1:0];
    assign w_c100 = 2'(w_yoe >= 9'd100) + 2'(w_yoe >= 9'd200) + 2'(w_yoe >= 9'd300);

    // month of the March-based year by comparing against month starts
    always_comb begin
        w_mp = '0;
        for (int i = 1; i < 12; i++) begin
            w_mp = w_mp + ecal_pkg::MP_W'(r_doy >= ecal_pkg::month_start(ecal_pkg::MP_W'(i)));
        end
    end
    assign w_dstart = ecal_pkg::month_start(w_mp);

    // January and February belong to the following civil year
    assign w_early = (r_mp >= 4'd10);

    // command decode
    always_comb begin
        n_dx    = r_dx;
        n_prod  = r_prod;
        n_dq    = r_dq;
        n_dqd   = r_dqd;
        n_dr    = r_dr;
        n_low7  = r_low7;
        n_sod   = r_sod;
        n_era5  = r_era5;
        n_doe   = r_doe;
        n_yoe   = r_yoe;
        n_ydays = r_ydays;
        n_doy   = r_doy;
        n_mp    = r_mp;
        n_day   = r_day;
        n_month = r_month;
        n_year  = r_year;
        n_hour  = r_hour;
        n_out_year   = r_out_year;
        n_out_month  = r_out_month;
        n_out_day    = r_out_day;
        n_out_hour   = r_out_hour;
        n_out_minute = r_out_minute;
        n_out_second = r_out_second;
        unique case (i_cmd.op)
            ecal_pkg::OP_LOAD: begin
                n_dx   = w_local[ecal_pkg::LOCAL_W-1:7];
                n_low7 = w_local[6:0];
            end
            ecal_pkg::OP_MUL: begin
                n_prod = ecal_pkg::PROD_W'(r_dx) * ecal_pkg::PROD_W'(w_div_m);
            end
            ecal_pkg::OP_QD: begin
                n_dq  = w_q0;
                n_dqd = w_qd_full[ecal_pkg::DX_W-1:0];
            end
            ecal_pkg::OP_FIX: begin
                if (w_rem >= ecal_pkg::DX_W'(w_div_d)) begin
                    n_dq = r_dq + 1'b1;
                    n_dr = ecal_pkg::DR_W'(w_rem - ecal_pkg::DX_W'(w_div_d));
                end else begin
                    n_dr = ecal_pkg::DR_W'(w_rem);
                end
            end
            ecal_pkg::OP_DAYS: begin
                n_sod  = {r_dr[9:0], r_low7};
                n_era5 = (w_days >= ecal_pkg::ERA5_FIRST);
                n_doe  = w_doe;
                n_dx   = ecal_pkg::DX_W'(w_doe);
            end
            ecal_pkg::OP_TSUM: begin
                n_dx = ecal_pkg::DX_W'(r_doe - ecal_pkg::DOE_W'(r_dq[6:0])
                                      + ecal_pkg::DOE_W'(w_c36524));
            end
            ecal_pkg::OP_YDAYS: begin
                n_yoe   = w_yoe;
                n_ydays = ecal_pkg::DOE_W'(w_yoe) * 18'd365
                        + ecal_pkg::DOE_W'(w_yoe[ecal_pkg::YOE_W-1:2])
                        - ecal_pkg::DOE_W'(w_c100);
            end
            ecal_pkg::OP_DOY: begin
                n_doy = ecal_pkg::DOY_W'(r_doe - r_ydays);
            end
            ecal_pkg::OP_MONTH: begin
                n_mp  = w_mp;
                n_day = ecal_pkg::DAY_W'(r_doy - w_dstart + 9'd1);
            end
            ecal_pkg::OP_DATE: begin
                n_month = w_early ? r_mp - 4'd9 : r_mp + 4'd3;
                n_year  = ecal_pkg::YEAR_W'(r_yoe)
                        + (r_era5 ? ecal_pkg::ERA5_YEAR : ecal_pkg::ERA4_YEAR)
                        + ecal_pkg::YEAR_W'(w_early);
                n_dx    = ecal_pkg::DX_W'(r_sod);
            end
            ecal_pkg::OP_HOUR: begin
                n_hour = r_dq[ecal_pkg::HOUR_W-1:0];
                n_dx   = ecal_pkg::DX_W'(r_dr);
            end
            ecal_pkg::OP_PUBLISH: begin
                n_out_year   = r_year;
                n_out_month  = r_month;
                n_out_day    = r_day;
                n_out_hour   = r_hour;
                n_out_minute = r_dq[ecal_pkg::MINUTE_W-1:0];
                n_out_second = r_dr[ecal_pkg::SECOND_W-1:0];
            end
            default: begin
            end
        endcase
    end

    // zone register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone <= ecal_pkg::ZONE_RESET;
        end else if (i_cfg_wr_en) begin
            r_zone <= i_cfg_wr_data;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_dx    <= n_dx;
        r_prod  <= n_prod;
        r_dq    <= n_dq;
        r_dqd   <= n_dqd;
        r_dr    <= n_dr;
        r_low7  <= n_low7;
        r_sod   <= n_sod;
        r_era5  <= n_era5;
        r_doe   <= n_doe;
        r_yoe   <= n_yoe;
        r_ydays <= n_ydays;
        r_doy   <= n_doy;
        r_mp    <= n_mp;
        r_day   <= n_day;
        r_month <= n_month;
        r_year  <= n_year;
        r_hour  <= n_hour;
        r_out_year   <= n_out_year;
        r_out_month  <= n_out_month;
        r_out_day    <= n_out_day;
        r_out_hour   <= n_out_hour;
        r_out_minute <= n_out_minute;
        r_out_second <= n_out_second;
    end

    assign o_year   = r_out_year;
    assign o_month  = r_out_month;
    assign o_day    = r_out_day;
    assign o_hour   = r_out_hour;
    assign o_minute = r_out_minute;
    assign o_second = r_out_second;

    // divider fix-up leaves a remainder below the divisor
    a_div_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(i_cmd.op) == ecal_pkg::OP_FIX)
        |-> (r_dr < $past(w_div_d)))
        else $error("divider remainder not below divisor");

    // quotient and remainder rebuild the dividend
    a_div_exact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(i_cmd.op) == ecal_pkg::OP_FIX)
        |-> (ecal_pkg::CHK_W'(r_dq) * ecal_pkg::CHK_W'($past(w_div_d))
             + ecal_pkg::CHK_W'(r_dr) == ecal_pkg::CHK_W'(r_dx)))
        else $error("divider quotient and remainder inconsistent");

    // month step gives a day from 1 and a month index below 12
    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(i_cmd.op) == ecal_pkg::OP_MONTH)
        |-> (r_day != 5'd0 && r_mp <= 4'd11))
        else $error("month step out of range");

endmodule

>>> rtl/ecal_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecal_ctrl - sequencer of the epoch-to-calendar converter
// Steps the datapath through the divisions and calendar steps, owns both
// handshakes and holds a finished beat until the receiver takes it.
// ----------------------------------------------------------------------------
module ecal_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    output logic            o_valid,
    input  logic            i_stall,
    output ecal_pkg::t_cmd  o_cmd
);

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] ST_IDLE    = 4'd0;
    localparam logic [ST_W-1:0] ST_MUL     = 4'd1;
    localparam logic [ST_W-1:0] ST_QD      = 4'd2;
    localparam logic [ST_W-1:0] ST_FIX     = 4'd3;
    localparam logic [ST_W-1:0] ST_DAYS    = 4'd4;
    localparam logic [ST_W-1:0] ST_TSUM    = 4'd5;
    localparam logic [ST_W-1:0] ST_YDAYS   = 4'd6;
    localparam logic [ST_W-1:0] ST_DOY     = 4'd7;
    localparam logic [ST_W-1:0] ST_MONTH   = 4'd8;
    localparam logic [ST_W-1:0] ST_DATE    = 4'd9;
    localparam logic [ST_W-1:0] ST_HOUR    = 4'd10;
    localparam logic [ST_W-1:0] ST_PUBLISH = 4'd11;

    logic [ST_W-1:0]             r_state, n_state;
    logic [ecal_pkg::DSEL_W-1:0] r_dsel,  n_dsel;
    logic                        r_out_valid, n_out_valid;
    logic                        w_accept;
    logic                        w_slot_free;
    logic                        w_publish;

    assign w_accept    = (r_state == ST_IDLE) && i_valid;
    assign w_slot_free = !r_out_valid || !i_stall;
    assign w_publish   = (r_state == ST_PUBLISH) && w_slot_free;

    // next state and divisor select
    always_comb begin
        n_state = r_state;
        n_dsel  = r_dsel;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_MUL;
                    n_dsel  = ecal_pkg::DV_DAY;
                end
            end
            ST_MUL:  n_state = ST_QD;
            ST_QD:   n_state = ST_FIX;
            ST_FIX: begin
                unique case (r_dsel)
                    ecal_pkg::DV_DAY:  n_state = ST_DAYS;
                    ecal_pkg::DV_CYC:  n_state = ST_TSUM;
                    ecal_pkg::DV_YEAR: n_state = ST_YDAYS;
                    ecal_pkg::DV_HOUR: n_state = ST_HOUR;
                    ecal_pkg::DV_MIN:  n_state = ST_PUBLISH;
                    default:           n_state = ST_IDLE;
                endcase
            end
            ST_DAYS: begin
                n_state = ST_MUL;
                n_dsel  = ecal_pkg::DV_CYC;
            end
            ST_TSUM: begin
                n_state = ST_MUL;
                n_dsel  = ecal_pkg::DV_YEAR;
            end
            ST_YDAYS: n_state = ST_DOY;
            ST_DOY:   n_state = ST_MONTH;
            ST_MONTH: n_state = ST_DATE;
            ST_DATE: begin
                n_state = ST_MUL;
                n_dsel  = ecal_pkg::DV_HOUR;
            end
            ST_HOUR: begin
                n_state = ST_MUL;
                n_dsel  = ecal_pkg::DV_MIN;
            end
            ST_PUBLISH: begin
                if (w_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // command to the datapath
    always_comb begin
        o_cmd.dsel = r_dsel;
        unique case (r_state)
            ST_IDLE:    o_cmd.op = w_accept ? ecal_pkg::OP_LOAD : ecal_pkg::OP_NONE;
            ST_MUL:     o_cmd.op = ecal_pkg::OP_MUL;
            ST_QD:      o_cmd.op = ecal_pkg::OP_QD;
            ST_FIX:     o_cmd.op = ecal_pkg::OP_FIX;
            ST_DAYS:    o_cmd.op = ecal_pkg::OP_DAYS;
            ST_TSUM:    o_cmd.op = ecal_pkg::OP_TSUM;
            ST_YDAYS:   o_cmd.op = ecal_pkg::OP_YDAYS;
            ST_DOY:     o_cmd.op = ecal_pkg::OP_DOY;
            ST_MONTH:   o_cmd.op = ecal_pkg::OP_MONTH;
            ST_DATE:    o_cmd.op = ecal_pkg::OP_DATE;
            ST_HOUR:    o_cmd.op = ecal_pkg::OP_HOUR;
            ST_PUBLISH: o_cmd.op = w_publish ? ecal_pkg::OP_PUBLISH : ecal_pkg::OP_NONE;
            default:    o_cmd.op = ecal_pkg::OP_NONE;
        endcase
    end

    // output beat held until taken
    always_comb begin
        if (w_publish) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_dsel      <= ecal_pkg::DV_DAY;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_dsel      <= n_dsel;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_out_valid;

    // a new result only ever comes out of the publish step
    a_valid_from_publish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $rose(r_out_valid)) |-> ($past(r_state) == ST_PUBLISH))
        else $error("result raised outside publish step");

    // publish is reached only after the last division
    a_publish_after_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PUBLISH) |-> (r_dsel == ecal_pkg::DV_MIN))
        else $error("publish reached before minute division");

    // a held result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == ecal_pkg::OP_PUBLISH) |-> (!r_out_valid || !i_stall))
        else $error("publish over a stalled result");

endmodule

>>> rtl/epoch_seconds_to_calendar.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar - epoch seconds to local Gregorian date and time
// Input channel: i_valid / o_stall carry i_epoch_seconds. A beat is taken at a
//   rising edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall carry year, month, day, hour, minute and
//   second. A beat is taken at a rising edge with o_valid high, i_stall low.
// Configuration: i_cfg_wr_en writes i_cfg_wr_data into the signed zone offset,
//   which is added to the epoch count. Write only while the block is idle.
// Sequencing: one item is in work at a time, so the block takes no new item
//   until the last one has been published. Each item makes five passes
//   through the one shared reciprocal divider (multiply, back-multiply,
//   fix-up) plus the calendar steps between them.
// Stall: a finished result waits in the output register; if it is still held
//   when the next result is ready, the sequencer waits in its last step and
//   o_stall stays high.
// Reset (synchronous, active low): both channels empty, zone offset 28800.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [ecal_pkg::EPOCH_W-1:0]   i_epoch_seconds,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [ecal_pkg::YEAR_W-1:0]    o_year,
    output logic [ecal_pkg::MONTH_W-1:0]   o_month,
    output logic [ecal_pkg::DAY_W-1:0]     o_day,
    output logic [ecal_pkg::HOUR_W-1:0]    o_hour,
    output logic [ecal_pkg::MINUTE_W-1:0]  o_minute,
    output logic [ecal_pkg::SECOND_W-1:0]  o_second,
    input  logic                           i_cfg_wr_en,
    input  logic [ecal_pkg::ZONE_W-1:0]    i_cfg_wr_data
);

    ecal_pkg::t_cmd w_cmd;

    // sequencer
    ecal_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (w_cmd)
    );

    // arithmetic and result register
    ecal_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_epoch_seconds (i_epoch_seconds),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .o_year          (o_year),
        .o_month         (o_month),
        .o_day           (o_day),
        .o_hour          (o_hour),
        .o_minute        (o_minute),
        .o_second        (o_second)
    );

endmodule
